// ===== sv/khist_pkg.sv =====
// khist_pkg: request and response types, operation and register codes,
// controller command/status structs and the base coding function.
// No dependencies.
package khist_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  base_char;
    logic [23:0] base_position;
    logic [23:0] read_length;
    logic [19:0] entry_key;
  } req_t;

  typedef struct packed {
    logic [31:0] entry_count;
    logic [39:0] entry_position_sum;
    logic [31:0] total_kmers;
    logic [20:0] distinct_kmers;
    logic        kmer_counted;
  } rsp_t;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_END_MODE   = 1'b0;
  localparam logic REG_TAIL_SHIFT = 1'b1;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_U = 8'h55;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;

  localparam int POS_BITS = 40;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef struct packed {
    logic load;
    logic decode;
    logic fetch;
    logic commit;
    logic sweep_start;
    logic sweep;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic sweep_last;
    logic out_free;
  } status_t;

  // {valid, 2-bit code}
  function automatic logic [2:0] base_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CHAR_A:         r = 3'b100;
      CHAR_T, CHAR_U: r = 3'b101;
      CHAR_C:         r = 3'b110;
      CHAR_G:         r = 3'b111;
      default:        r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/khist_ctrl.sv =====
// khist_ctrl: sequencing state machine for one request at a time and
// the table clearing sweep. Depends on khist_pkg.
module khist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  khist_pkg::status_t  status,
  output khist_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_COMMIT
  } state_t;

  state_t state, state_next;
  logic   reply, reply_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    reply_next = reply;
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = reply ? S_COMMIT : S_IDLE;
          reply_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (status.is_clear) begin
          cmd.sweep_start = 1'b1;
          reply_next      = 1'b1;
          state_next      = S_CLEAR;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  a_reply_in_clear: assert property (@(posedge clk) disable iff (rst)
    reply |-> state == S_CLEAR)
    else $error("clear reply pending outside sweep");

  a_commit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !status.out_free) |=> state == S_COMMIT)
    else $error("commit left while response slot busy");

  a_reset_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && status.sweep_last && !reply) |=> state == S_IDLE)
    else $error("reset sweep did not return to idle");

endmodule

// ===== sv/khist_dp.sv =====
// khist_dp: rolling key, window check, count/position table with
// saturating update, counters and response register. Depends on khist_pkg.
module khist_dp #(
  parameter int KEY_LEN    = 10,
  parameter int WINDOW     = 128,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  khist_pkg::cmd_t     cmd,
  output khist_pkg::status_t  status,
  input  khist_pkg::req_t     req_data,
  input  logic                end_mode,
  input  logic [7:0]          tail_shift,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output khist_pkg::rsp_t     rsp_data
);

  localparam int KEY_BITS   = 2 * KEY_LEN;
  localparam int TABLE_SIZE = 1 << KEY_BITS;
  localparam int RUN_BITS   = $clog2(KEY_LEN + 1);
  localparam int DIST_BITS  = KEY_BITS + 1;
  localparam int MEM_BITS   = COUNT_BITS + khist_pkg::POS_BITS;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b1, {KEY_BITS{1'b0}}};

  khist_pkg::req_t item;

  logic [KEY_BITS-1:0]   rolling_key;
  logic [RUN_BITS-1:0]   run;
  logic [KEY_BITS-1:0]   key_reg;
  logic                  cnt_ok;
  logic [23:0]           s_reg;
  logic signed [25:0]    last_reg;
  logic                  hit_reg;
  logic [23:0]           addend_reg;
  logic [KEY_BITS-1:0]   clr_addr;
  logic [31:0]           total, total_next;
  logic [DIST_BITS-1:0]  distinct, distinct_next;

  logic [MEM_BITS-1:0]   mem [0:TABLE_SIZE-1];
  logic [MEM_BITS-1:0]   rd_data;

  // decode stage
  logic [2:0]            code;
  logic [KEY_BITS-1:0]   key_base, key_shift;
  logic [RUN_BITS-1:0]   run_base, run_inc;
  logic                  run_ok;
  logic [7:0]            tail;
  logic [23:0]           s_val;
  logic signed [25:0]    last_val;

  assign code      = khist_pkg::base_code(item.base_char);
  assign key_base  = (item.base_position == 24'd0) ? '0 : rolling_key;
  assign run_base  = (item.base_position == 24'd0) ? '0 : run;
  assign key_shift = {key_base[KEY_BITS-3:0], code[1:0]};
  assign run_inc   = (run_base == RUN_BITS'(KEY_LEN)) ? run_base
                                                      : run_base + RUN_BITS'(1);
  assign run_ok    = (run_inc == RUN_BITS'(KEY_LEN)) &&
                     (item.base_position >= 24'(KEY_LEN - 1));
  assign tail      = (tail_shift == 8'd0) ? 8'd1 : tail_shift;
  assign s_val     = item.base_position - 24'(KEY_LEN - 1);
  assign last_val  = $signed({2'b00, item.read_length}) - $signed(26'(KEY_LEN))
                     - $signed({18'd0, tail});

  // window stage
  logic signed [25:0]    s_ext, first_val;
  logic                  in_range;
  logic [23:0]           addend;

  assign s_ext     = $signed({2'b00, s_reg});
  assign first_val = last_reg - $signed(26'(WINDOW));
  assign in_range  = (s_ext <= last_reg) &&
                     (end_mode ? (s_ext >= first_val) : (s_reg < 24'(WINDOW)));
  assign addend    = end_mode ? (item.read_length - s_reg) : s_reg;

  // update stage
  logic [COUNT_BITS-1:0]          cur_count, cnt_new;
  logic [khist_pkg::POS_BITS-1:0] cur_pos, pos_new;
  logic [khist_pkg::POS_BITS:0]   pos_sum;

  assign cur_count = rd_data[MEM_BITS-1:khist_pkg::POS_BITS];
  assign cur_pos   = rd_data[khist_pkg::POS_BITS-1:0];
  assign cnt_new   = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
  assign pos_sum   = {1'b0, cur_pos} + {17'd0, addend_reg};
  assign pos_new   = pos_sum[khist_pkg::POS_BITS] ? khist_pkg::POS_MAX
                                                  : pos_sum[khist_pkg::POS_BITS-1:0];

  always_comb begin
    total_next    = total;
    distinct_next = distinct;
    if (cmd.sweep_start) begin
      total_next    = '0;
      distinct_next = '0;
    end else if (cmd.commit && hit_reg) begin
      if (~&total) begin
        total_next = total + 32'd1;
      end
      if (cur_count == '0 && distinct != DIST_MAX) begin
        distinct_next = distinct + DIST_BITS'(1);
      end
    end
  end

  assign status.is_clear   = (item.operation == khist_pkg::OP_CLEAR);
  assign status.sweep_last = &clr_addr;
  assign status.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_key <= '0;
      run         <= '0;
      clr_addr    <= '0;
      total       <= '0;
      distinct    <= '0;
      rsp_valid   <= 1'b0;
      hit_reg     <= 1'b0;
    end else begin
      total    <= total_next;
      distinct <= distinct_next;
      if (cmd.sweep) begin
        clr_addr <= clr_addr + KEY_BITS'(1);
      end
      if (cmd.decode) begin
        hit_reg <= 1'b0;
        if (item.operation == khist_pkg::OP_ADD) begin
          rolling_key <= code[2] ? key_shift : '0;
          run         <= code[2] ? run_inc : '0;
        end
      end else if (cmd.fetch) begin
        hit_reg <= cnt_ok && in_range;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req_data;
    end
    if (cmd.decode) begin
      s_reg    <= s_val;
      last_reg <= last_val;
      if (item.operation == khist_pkg::OP_READ) begin
        key_reg <= KEY_BITS'(item.entry_key);
        cnt_ok  <= 1'b0;
      end else begin
        key_reg <= code[2] ? key_shift : '0;
        cnt_ok  <= (item.operation == khist_pkg::OP_ADD) && code[2] && run_ok;
      end
    end
    if (cmd.fetch) begin
      addend_reg <= addend;
    end
    if (cmd.commit) begin
      rsp_data.entry_count        <= (item.operation == khist_pkg::OP_READ)
                                     ? 32'(cur_count) : 32'd0;
      rsp_data.entry_position_sum <= (item.operation == khist_pkg::OP_READ)
                                     ? cur_pos : '0;
      rsp_data.total_kmers        <= total_next;
      rsp_data.distinct_kmers     <= 21'(distinct_next);
      rsp_data.kmer_counted       <= hit_reg;
    end
  end

  // count/position table
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[clr_addr] <= '0;
    end else if (cmd.commit && hit_reg) begin
      mem[key_reg] <= {cnt_new, pos_new};
    end
    if (cmd.fetch) begin
      rd_data <= mem[key_reg];
    end
  end

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run <= RUN_BITS'(KEY_LEN))
    else $error("valid run past key length");

  a_distinct_le_total: assert property (@(posedge clk) disable iff (rst)
    32'(distinct) <= total)
    else $error("distinct count above total");

  a_sweep_commit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep && cmd.commit))
    else $error("table write during sweep");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("response overwritten");

endmodule

// ===== sv/kmer_window_histogram.sv =====
// kmer_window_histogram: top level, configuration registers, controller
// and datapath. Depends on khist_pkg, khist_ctrl, khist_dp.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   req_data (khist_pkg::req_t)
//   rsp       out         rsp_valid / rsp_ready   rsp_data (khist_pkg::rsp_t)
//   cfg       in          cfg_we                  cfg_index, cfg_data
//
// requests pass accept, decode, table read, table write/response in order, one at a time
// clear request: decode, then the sweep, one table entry zeroed per cycle, then the response
// after reset the same sweep runs with req_ready low
// a response held by rsp_ready low stalls the table write stage; one finished
// response may wait in the output register while the next request is accepted
module kmer_window_histogram #(
  parameter int KEY_LEN    = 10,
  parameter int WINDOW     = 128,
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  khist_pkg::req_t  req_data,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output khist_pkg::rsp_t  rsp_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data
);

  logic               end_mode;
  logic [7:0]         tail_shift;
  khist_pkg::cmd_t    cmd;
  khist_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_mode   <= 1'b0;
      tail_shift <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        khist_pkg::REG_END_MODE:   end_mode   <= cfg_data[0];
        khist_pkg::REG_TAIL_SHIFT: tail_shift <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  khist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  khist_dp #(
    .KEY_LEN    (KEY_LEN),
    .WINDOW     (WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_data   (req_data),
    .end_mode   (end_mode),
    .tail_shift (tail_shift),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data)
  );

endmodule
